[rtl/core/percent_escape_decoder_assert.svh]
`ifndef PERCENT_ESCAPE_DECODER_ASSERT_SVH
`define PERCENT_ESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define PD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define PD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pd_pkg.sv]
package pd_pkg;

  localparam int unsigned CODE_W = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CODE_W-1:0] CH_PERCENT = 16'h0025;
  localparam logic [CODE_W-1:0] CH_0 = 16'h0030;
  localparam logic [CODE_W-1:0] CH_9 = 16'h0039;
  localparam logic [CODE_W-1:0] CH_LA = 16'h0061;
  localparam logic [CODE_W-1:0] CH_LF = 16'h0066;
  localparam logic [CODE_W-1:0] CH_UA = 16'h0041;
  localparam logic [CODE_W-1:0] CH_UF = 16'h0046;
  localparam logic [CODE_W-1:0] HEX_TEN = 16'd10;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_code;
    logic is_end;
    logic last_of_run;
  } out_item_t;

  // One queued command covers all results of one item: an optional '%', an
  // optional held digit and an optional final character, in that order.
  typedef struct packed {
    logic emit_pct;
    logic emit_held;
    logic emit_fin;
    logic [CODE_W-1:0] held_code;
    logic [CODE_W-1:0] fin_code;
    logic fin_end;
  } cmd_t;

  function automatic logic is_hex(input logic [CODE_W-1:0] c);
    is_hex = ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LF)) ||
             ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] v;
    v = '0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      v = c - CH_0;
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      v = c - CH_LA + HEX_TEN;
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      v = c - CH_UA + HEX_TEN;
    end
    hex_val = v[3:0];
  endfunction

endpackage

[rtl/core/pd_front.sv]
module pd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pd_pkg::in_item_t in_item,
  input  logic            q_full,
  output logic            q_push,
  output pd_pkg::cmd_t    q_cmd
);
  import pd_pkg::*;

  logic [1:0]        phase_r, phase_nxt;
  logic [CODE_W-1:0] held_r, held_nxt;
  logic              accept;
  logic              c_hex;
  logic              c_pct;
  cmd_t              cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c_hex    = is_hex(in_item.char_code);
  assign c_pct    = (in_item.char_code == CH_PERCENT);

  always_comb begin
    cmd           = '0;
    cmd.held_code = held_r;
    cmd.fin_code  = in_item.char_code;
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    if (in_item.end_of_text) begin
      cmd.emit_pct  = (phase_r == PH_PCT) || (phase_r == PH_DIGIT);
      cmd.emit_held = (phase_r == PH_DIGIT);
      cmd.emit_fin  = 1'b1;
      cmd.fin_code  = '0;
      cmd.fin_end   = 1'b1;
      phase_nxt     = PH_IDLE;
      held_nxt      = '0;
    end else begin
      case (phase_r)
        PH_PCT: begin
          if (c_hex) begin
            held_nxt  = in_item.char_code;
            phase_nxt = PH_DIGIT;
          end else begin
            cmd.emit_pct = 1'b1;
            cmd.emit_fin = !c_pct;
            phase_nxt    = c_pct ? PH_PCT : PH_IDLE;
          end
        end
        PH_DIGIT: begin
          if (c_hex) begin
            cmd.emit_fin = 1'b1;
            cmd.fin_code = {{(CODE_W-8){1'b0}}, hex_val(held_r), hex_val(in_item.char_code)};
            phase_nxt    = PH_IDLE;
          end else begin
            cmd.emit_pct  = 1'b1;
            cmd.emit_held = 1'b1;
            cmd.emit_fin  = !c_pct;
            phase_nxt     = c_pct ? PH_PCT : PH_IDLE;
          end
        end
        default: begin
          // The unused phase code behaves like idle.
          cmd.emit_fin = !c_pct;
          phase_nxt    = c_pct ? PH_PCT : PH_IDLE;
        end
      endcase
    end
  end

  assign q_push = accept && (cmd.emit_pct || cmd.emit_held || cmd.emit_fin);
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

[rtl/core/pd_queue.sv]
module pd_queue #(
  parameter int unsigned DEPTH = pd_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  pd_pkg::cmd_t push_cmd,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output pd_pkg::cmd_t head_cmd
);
  import pd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign head_cmd = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

endmodule

[rtl/core/pd_back.sv]
module pd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  pd_pkg::cmd_t     head_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output pd_pkg::out_item_t out_item
);
  import pd_pkg::*;

  logic [2:0] rem_r, rem_nxt;
  logic [2:0] live;
  logic [2:0] pick;
  logic [2:0] rest;
  logic       load;
  logic       emit;
  logic       out_valid_r;
  out_item_t  out_item_r, out_item_nxt;

  // Bit 2 is the '%', bit 1 the held digit, bit 0 the final character.
  assign live = {head_cmd.emit_pct, head_cmd.emit_held, head_cmd.emit_fin} & rem_r;
  assign pick = live[2] ? 3'b100 : (live[1] ? 3'b010 : 3'b001);
  assign rest = live & ~pick;
  assign load = !out_valid_r || !out_stall;
  assign emit = load && !q_empty;
  assign q_pop = emit && (rest == 3'b000);

  always_comb begin
    out_item_nxt.last_of_run = (rest == 3'b000);
    out_item_nxt.is_end      = 1'b0;
    if (pick[2]) begin
      out_item_nxt.out_code = CH_PERCENT;
    end else if (pick[1]) begin
      out_item_nxt.out_code = head_cmd.held_code;
    end else begin
      out_item_nxt.out_code = head_cmd.fin_code;
      out_item_nxt.is_end   = head_cmd.fin_end;
    end
    rem_nxt = q_pop ? 3'b111 : (rem_r & ~pick);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rem_r       <= 3'b111;
    end else begin
      if (load) begin
        out_valid_r <= !q_empty;
      end
      if (emit) begin
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/core/percent_escape_decoder.sv]
// Streaming percent-escape decoder, one text character per input item.
// Input channel: in_valid / in_stall / in_item (char_code, end_of_text).
// Output channel: out_valid / out_stall / out_item (out_code, is_end,
// last_of_run). An item is taken on a clock edge with valid high and stall low.
// A front stage classifies each item against the escape phase and queues one
// command holding all of its results, if it has any; a back stage plays the
// command out one result per cycle, while out_stall is low, into a registered
// output. A result passes through the command queue and the output register.
// Throughput: one item per cycle while each item makes at most one result and
// out_stall stays low; an item that makes two or three results holds the back
// stage until all are out, and the command queue (QUEUE_DEPTH entries) absorbs
// such bursts. A '%' in idle or an escape's first digit makes no result and
// costs the back stage nothing. in_stall rises only when the queue is full.
// When out_stall is high the output register holds its item unchanged and the
// queue keeps filling until it is full. Synchronous reset (rst_n low) empties
// the queue, drops any pending output and returns the phase to idle.
module percent_escape_decoder #(
  parameter int unsigned QUEUE_DEPTH = pd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pd_pkg::in_item_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output pd_pkg::out_item_t out_item
);
  import pd_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, head_cmd;

  pd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  pd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  pd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_cmd  (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/core/pd_checker.sv]
`include "percent_escape_decoder_assert.svh"

module pd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input pd_pkg::in_item_t  in_item,
  input logic              out_valid,
  input logic              out_stall,
  input pd_pkg::out_item_t out_item
);
  import pd_pkg::*;

  logic in_take;
  logic end_taken;

  assign in_take   = in_valid && !in_stall;
  assign end_taken = in_take && in_item.end_of_text;

  `PD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled output item changed")

  // The end marker always carries a zero code and closes its item's results.
  `PD_ASSERT_NOW(a_end_shape, out_valid && out_item.is_end, (out_item.out_code == '0) && out_item.last_of_run, "malformed end marker")

  // Results of one item leave back to back once the first has been taken.
  `PD_ASSERT_NEXT(a_run_contig, out_valid && !out_stall && !out_item.last_of_run, out_valid, "gap inside a run of results")

  // A taken end item is written into the command queue, which then makes the output valid.
  `PD_ASSERT_NEXT(a_end_drains, end_taken, ##1 out_valid, "end item lost")

endmodule

bind percent_escape_decoder pd_checker u_pd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pd_pkg::*;

  // One row of the directed table. Rows with typed set carry their single
  // expected result (or none), the rest are left to the predictor.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eot;
    logic              typed;
    logic              has_out;
    logic [CODE_W-1:0] exp_code;
    logic              exp_end;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic [1:0]        esc_phase;
  logic [CODE_W-1:0] held_char;
  out_item_t         step_chars[$];
  out_item_t         predicted_chars[$];
  out_item_t         want;
  int unsigned       mismatches = 0;
  int unsigned       burst_left;
  int unsigned       stall_left = 0;
  int unsigned       stall_mode = 0;
  int unsigned       stall_pct = 0;
  dir_row_t          directed_rows[DIR_ROWS];

  percent_escape_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] nibble_of(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] d;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 16'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 16'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic void emit_char(input logic [CODE_W-1:0] code, input logic eot);
    out_item_t r;
    r.out_code = code;
    r.is_end = eot;
    r.last_of_run = 1'b0;
    step_chars.push_back(r);
  endfunction

  // Advances the decoder state by one item and leaves its results in step_chars.
  function automatic void predict_decode(input in_item_t it);
    logic [4:0]        nib;
    logic [4:0]        held_nib;
    logic [CODE_W-1:0] c;
    step_chars.delete();
    c = it.char_code;
    nib = nibble_of(c);
    held_nib = nibble_of(held_char);
    if (it.end_of_text) begin
      if (esc_phase == PH_PCT) begin
        emit_char(CH_PERCENT, 1'b0);
      end else if (esc_phase == PH_DIGIT) begin
        emit_char(CH_PERCENT, 1'b0);
        emit_char(held_char, 1'b0);
      end
      emit_char('0, 1'b1);
      esc_phase = PH_IDLE;
      held_char = '0;
    end else if (esc_phase == PH_PCT && nib[4]) begin
      held_char = c;
      esc_phase = PH_DIGIT;
    end else if (esc_phase == PH_DIGIT && nib[4]) begin
      emit_char({8'h00, held_nib[3:0], nib[3:0]}, 1'b0);
      esc_phase = PH_IDLE;
    end else begin
      // A broken escape gives back what it held, then the character is seen
      // as if no escape had been open.
      if (esc_phase == PH_PCT) begin
        emit_char(CH_PERCENT, 1'b0);
      end else if (esc_phase == PH_DIGIT) begin
        emit_char(CH_PERCENT, 1'b0);
        emit_char(held_char, 1'b0);
      end
      if (c == CH_PERCENT) begin
        esc_phase = PH_PCT;
      end else begin
        esc_phase = PH_IDLE;
        emit_char(c, 1'b0);
      end
    end
    if (step_chars.size() > 0) begin
      step_chars[step_chars.size()-1].last_of_run = 1'b1;
    end
  endfunction

  function automatic logic [CODE_W-1:0] pick_hex();
    int unsigned idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) return CH_0 + CODE_W'(idx);
    if (idx < 16) return CH_LA + CODE_W'(idx - 10);
    return CH_UA + CODE_W'(idx - 16);
  endfunction

  function automatic logic [CODE_W-1:0] pick_nonhex();
    logic [CODE_W-1:0] c;
    logic [CODE_W-1:0] h;
    logic [7:0]        hb;
    logic [4:0]        nib;
    hb = 8'($urandom_range(1, 255));
    h = pick_hex();
    case ($urandom_range(0, 8))
      0: c = 16'h002F;
      1: c = 16'h003A;
      2: c = 16'h0040;
      3: c = 16'h0047;
      4: c = 16'h0060;
      5: c = 16'h0067;
      6: c = CH_PERCENT;
      7: c = {hb, h[7:0]};
      default: c = CODE_W'($urandom);
    endcase
    nib = nibble_of(c);
    if (nib[4]) begin
      c = c | 16'h0100;
    end
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] pick_plain();
    logic [CODE_W-1:0] c;
    if ($urandom_range(0, 9) < 7) begin
      c = CODE_W'($urandom_range(16'h0020, 16'h007E));
    end else begin
      c = CODE_W'($urandom);
    end
    if (c == CH_PERCENT) begin
      c = 16'h0078;
    end
    return c;
  endfunction

  task automatic idle_cycles(input int unsigned n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Sender bursts: a random run of back-to-back items, then a random gap.
  task automatic pace();
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (predicted_chars.size() != 0) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input dir_row_t row);
    in_item_t  it;
    out_item_t r;
    it.char_code = row.code;
    it.end_of_text = row.eot;
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_decode(it);
    if (row.typed) begin
      if (row.has_out) begin
        r.out_code = row.exp_code;
        r.is_end = row.exp_end;
        r.last_of_run = 1'b1;
        predicted_chars.push_back(r);
      end
    end else begin
      foreach (step_chars[i]) predicted_chars.push_back(step_chars[i]);
    end
    @(negedge clk);
  endtask

  task automatic feed(input logic [CODE_W-1:0] code, input logic eot);
    dir_row_t row;
    row = '0;
    row.code = code;
    row.eot = eot;
    pace();
    send_item(row);
  endtask

  // Receiver stall pattern: stretches of no stall, light or heavy random
  // stalls, and short solid stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 8) : $urandom_range(5, 40);
      stall_pct = (stall_mode == 1) ? 25 : 60;
    end
    stall_left--;
    if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_mode == 3) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_chars.size() == 0) begin
        $error("unexpected item: out_code %h is_end %b last_of_run %b",
               out_item.out_code, out_item.is_end, out_item.last_of_run);
        mismatches++;
      end else begin
        want = predicted_chars.pop_front();
        if (out_item.out_code !== want.out_code) begin
          $error("out_code: expected %h, got %h", want.out_code, out_item.out_code);
          mismatches++;
        end
        if (out_item.is_end !== want.is_end) begin
          $error("is_end: expected %b, got %b", want.is_end, out_item.is_end);
          mismatches++;
        end
        if (out_item.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run,
                 out_item.last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned rand_items;
    int unsigned tokens;
    int unsigned pick;
    logic [CODE_W-1:0] h;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    esc_phase = PH_IDLE;
    held_char = '0;
    burst_left = 0;

    // code, end, typed, has_out, expected code, expected end
    directed_rows[0]  = '{CH_UA,       1'b0, 1'b1, 1'b1, CH_UA,   1'b0};
    directed_rows[1]  = '{16'h0000,    1'b0, 1'b1, 1'b1, 16'h0000, 1'b0};
    directed_rows[2]  = '{16'hFFFF,    1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0};
    directed_rows[3]  = '{CH_PERCENT,  1'b0, 1'b1, 1'b0, 16'h0000, 1'b0};
    directed_rows[4]  = '{16'h0034,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0};
    directed_rows[5]  = '{16'h0031,    1'b0, 1'b1, 1'b1, 16'h0041, 1'b0};
    directed_rows[6]  = '{CH_PERCENT,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[7]  = '{CH_LF,       1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[8]  = '{CH_UF,       1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[9]  = '{CH_PERCENT,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[10] = '{CH_PERCENT,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[11] = '{CH_9,        1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[12] = '{16'h007A,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[13] = '{CH_PERCENT,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[14] = '{16'h0125,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[15] = '{CH_PERCENT,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[16] = '{CH_LA,       1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[17] = '{16'h0130,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[18] = '{CH_PERCENT,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[19] = '{16'h0042,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[20] = '{16'hFFFF,    1'b1, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[21] = '{CH_PERCENT,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[22] = '{16'h0000,    1'b1, 1'b0, 1'b0, 16'h0000, 1'b0};
    directed_rows[23] = '{16'h1234,    1'b1, 1'b1, 1'b1, 16'h0000, 1'b1};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      pace();
      send_item(directed_rows[i]);
    end
    drain();

    // Mostly well-formed text with valid escapes, some broken escapes,
    // ends in every phase, and raw 16-bit noise.
    rand_items = 0;
    tokens = 0;
    while (rand_items < 386) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        feed(pick_plain(), 1'b0);
        rand_items += 1;
      end else if (pick < 68) begin
        feed(CH_PERCENT, 1'b0);
        feed(pick_hex(), 1'b0);
        feed(pick_hex(), 1'b0);
        rand_items += 3;
      end else if (pick < 84) begin
        feed(CH_PERCENT, 1'b0);
        case ($urandom_range(0, 2))
          0: begin
            feed(pick_nonhex(), 1'b0);
            rand_items += 2;
          end
          1: begin
            feed(pick_hex(), 1'b0);
            feed(pick_nonhex(), 1'b0);
            rand_items += 3;
          end
          default: begin
            feed(CH_PERCENT, 1'b0);
            rand_items += 2;
          end
        endcase
      end else if (pick < 92) begin
        // End items arrive in any phase, with a junk code that must be ignored.
        if ($urandom_range(0, 2) == 0) begin
          feed(CH_PERCENT, 1'b0);
          rand_items += 1;
          if ($urandom_range(0, 1) == 0) begin
            feed(pick_hex(), 1'b0);
            rand_items += 1;
          end
        end
        h = CODE_W'($urandom);
        feed(h, 1'b1);
        rand_items += 1;
      end else begin
        h = CODE_W'($urandom);
        feed(h, 1'b0);
        rand_items += 1;
      end
      tokens++;
      if (tokens % 60 == 0) begin
        drain();
      end
    end

    in_valid = 1'b0;
    while (predicted_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
